>>> rtl/sgr_pkg.sv
`timescale 1ns / 1ps

package sgr_pkg;

	typedef enum logic [3:0] {
		OP_NOP        = 4'd0,
		OP_RESET      = 4'd1,
		OP_FG_BRT_SET = 4'd2,
		OP_FG_BRT_CLR = 4'd3,
		OP_BG_BRT_SET = 4'd4,
		OP_BG_BRT_CLR = 4'd5,
		OP_FG_COLOUR  = 4'd6,
		OP_FG_DEFAULT = 4'd7,
		OP_BG_COLOUR  = 4'd8,
		OP_BG_DEFAULT = 4'd9,
		OP_EXTENDED   = 4'd10
	} sgr_op_t;

	typedef enum logic [1:0] {
		SEL_OTHER = 2'd0,
		SEL_RGB   = 2'd1,
		SEL_INDEX = 2'd2
	} sgr_sel_t;

	typedef struct packed {
		sgr_op_t     op;
		logic [2:0]  colour;
		sgr_sel_t    sel;
		logic        last;
		logic        seq_empty;
	} sgr_dec_t;

	localparam int unsigned DEC_W = $bits(sgr_dec_t);

	localparam logic [2:0] SKIP_NONE     = 3'd0;
	localparam logic [2:0] SKIP_SELECTOR = 3'd1;
	localparam logic [2:0] SKIP_THREE    = 3'd4;
	localparam logic [2:0] SKIP_ONE      = 3'd2;

	localparam logic [7:0] MASK_FG_KEEP  = 8'hf8;
	localparam logic [7:0] MASK_BG_KEEP  = 8'h8f;
	localparam logic [7:0] BIT_FG_BRIGHT = 8'h08;
	localparam logic [7:0] BIT_BG_BRIGHT = 8'h80;
	localparam logic [7:0] MASK_BG_FIELD = 8'h70;
	localparam logic [7:0] MASK_FG_FIELD = 8'h07;

	function automatic logic [2:0] colour_map(input logic [2:0] idx);
		logic [2:0] r;
		unique case (idx)
			3'd0: r = 3'd0;
			3'd1: r = 3'd4;
			3'd2: r = 3'd2;
			3'd3: r = 3'd6;
			3'd4: r = 3'd1;
			3'd5: r = 3'd5;
			3'd6: r = 3'd3;
			3'd7: r = 3'd7;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/sgr_to_text_attribute_top.sv
`timescale 1ns / 1ps
// Path: a word accepted at the input is held in the decode register, then the decode queue;
//   the back end applies it and, for the last word of a sequence, pushes the attribute
//   into the result queue; the path stalls only while the result queue is full.
// Throughput: one word per cycle while the result queue is not full; the back end's
//   attribute update is a read-modify-write of the attribute and skip registers.
// Reset: arst_n clears both queues, sets the attribute and default attribute to 0x07.
module sgr_to_text_attribute_top #(
	parameter int unsigned DEC_DEPTH = 4,
	parameter int unsigned RES_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] param_value,
	input  logic        last_param,
	input  logic        empty_sequence,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  attribute,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import sgr_pkg::*;

	logic [7:0]       default_attr_q;
	logic             dec_push;
	logic             dec_full;
	logic             dec_empty;
	logic             dec_pop;
	sgr_dec_t         dec_in;
	sgr_dec_t         dec_out;
	logic [DEC_W-1:0] dec_rdata;
	logic             res_push;
	logic             res_full;
	logic [7:0]       res_attr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= 8'h07;
		end else if (cfg_valid) begin
			default_attr_q <= cfg_data;
		end
	end

	sgr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.param_value    (param_value),
		.last_param     (last_param),
		.empty_sequence (empty_sequence),
		.dec_push       (dec_push),
		.dec_word       (dec_in),
		.dec_full       (dec_full)
	);

	sgr_fifo #(
		.WIDTH (DEC_W),
		.DEPTH (DEC_DEPTH)
	) u_dec_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (dec_push),
		.wdata  (dec_in),
		.full   (dec_full),
		.pop    (dec_pop),
		.rdata  (dec_rdata),
		.empty  (dec_empty)
	);

	assign dec_out = sgr_dec_t'(dec_rdata);

	sgr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.default_attr (default_attr_q),
		.dec_word     (dec_out),
		.dec_empty    (dec_empty),
		.dec_pop      (dec_pop),
		.res_push     (res_push),
		.res_attr     (res_attr),
		.res_full     (res_full)
	);

	sgr_fifo #(
		.WIDTH (8),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_attr),
		.full   (res_full),
		.pop    (pop),
		.rdata  (attribute),
		.empty  (empty)
	);

endmodule

>>> rtl/sgr_fifo.sv
`timescale 1ns / 1ps

module sgr_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/sgr_front.sv
`timescale 1ns / 1ps

module sgr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [15:0]      param_value,
	input  logic             last_param,
	input  logic             empty_sequence,
	output logic             dec_push,
	output sgr_pkg::sgr_dec_t dec_word,
	input  logic             dec_full
);
	import sgr_pkg::*;

	logic     valid_s1;
	sgr_dec_t dec_s1;
	sgr_dec_t dec_d;
	logic     in_ready;
	logic     accept;
	logic [2:0] fg_off;
	logic [2:0] bg_off;

	assign in_ready = !valid_s1 || !dec_full;
	assign full     = !in_ready;
	assign accept   = push && in_ready;
	assign dec_push = valid_s1 && !dec_full;
	assign dec_word = dec_s1;

	assign fg_off = param_value[2:0] - 3'd6;
	assign bg_off = param_value[2:0];

	always_comb begin
		dec_d.op        = OP_NOP;
		dec_d.colour    = 3'd0;
		dec_d.last      = last_param;
		dec_d.seq_empty = empty_sequence;
		if (param_value == 16'd2) begin
			dec_d.sel = SEL_RGB;
		end else if (param_value == 16'd5) begin
			dec_d.sel = SEL_INDEX;
		end else begin
			dec_d.sel = SEL_OTHER;
		end
		priority if (param_value == 16'd0) begin
			dec_d.op = OP_RESET;
		end else if (param_value == 16'd1) begin
			dec_d.op = OP_FG_BRT_SET;
		end else if (param_value == 16'd2 || param_value == 16'd22) begin
			dec_d.op = OP_FG_BRT_CLR;
		end else if (param_value == 16'd4) begin
			dec_d.op = OP_BG_BRT_SET;
		end else if (param_value == 16'd24) begin
			dec_d.op = OP_BG_BRT_CLR;
		end else if (param_value >= 16'd30 && param_value <= 16'd37) begin
			dec_d.op     = OP_FG_COLOUR;
			dec_d.colour = colour_map(fg_off);
		end else if (param_value == 16'd39) begin
			dec_d.op = OP_FG_DEFAULT;
		end else if (param_value >= 16'd40 && param_value <= 16'd47) begin
			dec_d.op     = OP_BG_COLOUR;
			dec_d.colour = colour_map(bg_off);
		end else if (param_value == 16'd49) begin
			dec_d.op = OP_BG_DEFAULT;
		end else if (param_value == 16'd38 || param_value == 16'd48) begin
			dec_d.op = OP_EXTENDED;
		end else begin
			dec_d.op = OP_NOP;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (dec_push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

>>> rtl/sgr_back.sv
`timescale 1ns / 1ps

module sgr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        default_attr,
	input  sgr_pkg::sgr_dec_t dec_word,
	input  logic              dec_empty,
	output logic              dec_pop,
	output logic              res_push,
	output logic [7:0]        res_attr,
	input  logic              res_full
);
	import sgr_pkg::*;

	logic [7:0] attr_q;
	logic [2:0] skip_q;
	logic [7:0] attr_d;
	logic [2:0] skip_d;
	logic [2:0] skip_dec;
	logic       take;
	logic       emit;

	assign take     = !dec_empty && !res_full;
	assign dec_pop  = take;
	assign emit     = dec_word.seq_empty || dec_word.last;
	assign res_push = take && emit;
	assign res_attr = attr_d;
	assign skip_dec = skip_q - 3'd1;

	always_comb begin
		attr_d = attr_q;
		skip_d = skip_q;
		if (!dec_word.seq_empty) begin
			priority if (skip_q == SKIP_SELECTOR) begin
				unique case (dec_word.sel)
					SEL_RGB:   skip_d = SKIP_THREE;
					SEL_INDEX: skip_d = SKIP_ONE;
					default:   skip_d = SKIP_NONE;
				endcase
			end else if (skip_q != SKIP_NONE) begin
				skip_d = (skip_dec == SKIP_SELECTOR) ? SKIP_NONE : skip_dec;
			end else begin
				unique case (dec_word.op)
					OP_RESET:      attr_d = default_attr;
					OP_FG_BRT_SET: attr_d = attr_q | BIT_FG_BRIGHT;
					OP_FG_BRT_CLR: attr_d = attr_q & ~BIT_FG_BRIGHT;
					OP_BG_BRT_SET: attr_d = attr_q | BIT_BG_BRIGHT;
					OP_BG_BRT_CLR: attr_d = attr_q & ~BIT_BG_BRIGHT;
					OP_FG_COLOUR:  attr_d = (attr_q & MASK_FG_KEEP) | {5'd0, dec_word.colour};
					OP_FG_DEFAULT: attr_d = (attr_q & MASK_FG_KEEP) | (default_attr & MASK_FG_FIELD);
					OP_BG_COLOUR:  attr_d = (attr_q & MASK_BG_KEEP) | {1'b0, dec_word.colour, 4'd0};
					OP_BG_DEFAULT: attr_d = (attr_q & MASK_BG_KEEP) | (default_attr & MASK_BG_FIELD);
					OP_EXTENDED:   skip_d = SKIP_SELECTOR;
					default:       attr_d = attr_q;
				endcase
			end
		end
		if (emit) begin
			skip_d = SKIP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= 8'h07;
			skip_q <= SKIP_NONE;
		end else if (take) begin
			attr_q <= attr_d;
			skip_q <= skip_d;
		end
	end

endmodule
